// ===== rtl/core/ssp_pkg.sv =====
`default_nettype none
package ssp_pkg;

  // result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_NOT_PREF  = 3'd3,
    ST_FULL      = 3'd4,
    ST_BAD_SHARD = 3'd5,
    ST_LIST      = 3'd6,
    ST_LIST_EMPTY = 3'd7
  } ssp_status_e;

  localparam int unsigned KeyBits    = 256;
  localparam int unsigned NonceBits  = 64;
  localparam int unsigned ShardBits  = 16;
  localparam int unsigned CountBits  = 17;

  // stored entry body, handle kept alongside in the RAM word
  typedef struct packed {
    logic [KeyBits-1:0]   sender;
    logic [NonceBits-1:0] nonce;
    logic [KeyBits-1:0]   hash;
  } ssp_key_t;

endpackage
`default_nettype wire

// ===== rtl/core/ssp_ram.sv =====
`default_nettype none
module ssp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic                                    re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port; read data holds until next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sharded_sorted_pending_pool.sv =====
// Sharded sorted pending pool.
// Input channel (in_valid_i/in_ready_o) takes one item: a submit of a
// transfer entry or a list request for a shard. Output channel
// (out_valid_o/out_ready_i) returns one result per submit, or one result
// per stored entry of a listed shard (last_o marks the final one).
// cfg_we_i/cfg_wdata_i write the shard limit; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// One item is handled at a time. A submit walks the bucket table one
// bucket a cycle (up to BUCKETS buckets), then reads each stored entry
// in S_MRD and checks it for a sender/nonce match in S_MCHK, then shifts
// larger entries up by one slot, reading each in S_INS and writing it in
// S_ICHK, as the entry RAM has a single read port. A submit frees the
// input as its result is registered; a list reads each entry in S_LRD
// and returns it from S_LWAIT. A bad shard skips the bucket scan.
// The output is registered: a new item is taken while the last result
// still waits, and a stalled receiver only holds up list results or the
// result of the item after. Reset empties every bucket and sets the
// shard limit to 1; the entry RAM needs no clearing pass.
`default_nettype none
module sharded_sorted_pending_pool
  import ssp_pkg::*;
#(
  parameter int unsigned BUCKETS     = 8,
  parameter int unsigned PER_SHARD   = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [15:0] shard_id_i,
  input  wire logic [63:0] sender_w0_i,
  input  wire logic [63:0] sender_w1_i,
  input  wire logic [63:0] sender_w2_i,
  input  wire logic [63:0] sender_w3_i,
  input  wire logic [63:0] nonce_i,
  input  wire logic [63:0] hash_w0_i,
  input  wire logic [63:0] hash_w1_i,
  input  wire logic [63:0] hash_w2_i,
  input  wire logic [63:0] hash_w3_i,
  input  wire logic [15:0] frame_handle_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [15:0]      shard_out_o,
  output logic [4:0]       bucket_len_o,
  output logic [63:0]      result_hash_w0_o,
  output logic [63:0]      result_hash_w1_o,
  output logic [63:0]      result_hash_w2_o,
  output logic [63:0]      result_hash_w3_o,
  output logic [15:0]      out_handle_o,
  output logic             last_o
);

  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned PW    = (PER_SHARD > 1) ? $clog2(PER_SHARD) : 1;
  localparam int unsigned CW    = $clog2(PER_SHARD + 1);
  localparam int unsigned SLOTS = BUCKETS * PER_SHARD;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned EW    = $bits(ssp_key_t) + HANDLE_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DSCAN = 4'd1;
  localparam logic [3:0] S_LRD   = 4'd2;
  localparam logic [3:0] S_LWAIT = 4'd3;
  localparam logic [3:0] S_MRD   = 4'd4;
  localparam logic [3:0] S_MCHK  = 4'd5;
  localparam logic [3:0] S_INS   = 4'd6;
  localparam logic [3:0] S_ICHK  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  // configuration
  logic [CountBits-1:0] shard_lim_q;

  // bucket directory, valid through a non-zero fill
  logic [CW-1:0]        fill_q  [BUCKETS];
  logic [CW-1:0]        fill_d  [BUCKETS];
  logic [ShardBits-1:0] bshard_q [BUCKETS];
  logic [ShardBits-1:0] bshard_d [BUCKETS];

  // sequencer
  logic [3:0]  state_q, state_d;
  logic [BW:0] bsc_q, bsc_d;
  logic        have_empty_q, have_empty_d;
  logic [BW-1:0] empty_q, empty_d;
  logic [BW-1:0] tgt_q, tgt_d;
  logic        newb_q, newb_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] at_q, at_d;
  ssp_status_e res_status_q, res_status_d;
  logic [CW-1:0] res_cnt_q, res_cnt_d;

  // latched item
  logic                 in_action_q;
  logic [ShardBits-1:0] in_shard_q;
  ssp_key_t             in_key_q;
  logic [HANDLE_BITS-1:0] in_handle_q;

  // output register
  logic        out_valid_q, out_valid_d;
  ssp_status_e out_status_q, out_status_d;
  logic [ShardBits-1:0] out_shard_q, out_shard_d;
  logic [4:0]  out_cnt_q, out_cnt_d;
  logic [KeyBits-1:0] out_hash_q, out_hash_d;
  logic [15:0] out_handle_q, out_handle_d;
  logic        out_last_q, out_last_d;

  // entry RAM
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  ssp_key_t      rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;

  logic          in_acc, out_free;
  logic [BW-1:0] bsc_idx;
  logic [CW-1:0] cur_fill;
  logic [ShardBits-1:0] cur_shard;
  logic          e_hit, f_hit, scan_end, dir_found, dir_empty;
  logic [BW-1:0] empty_sel;
  logic          key_match, hash_gt, hash_lt, new_lt;
  logic [CW:0]   i_next;
  logic [31:0]   fh_ext, rh_ext, cnt_ext_res, cnt_ext_n;
  logic [EW-1:0] new_entry;

  ssp_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  function automatic logic [AW-1:0] slot_addr(logic [BW-1:0] b, logic [CW-1:0] s);
    logic [PW-1:0] sl;
    sl = s[PW-1:0];
    return AW'(AW'(b) * AW'(PER_SHARD) + AW'(sl));
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign {rd_key, rd_handle} = ram_rdata;
  assign fh_ext    = 32'(frame_handle_i);
  assign rh_ext    = 32'(rd_handle);
  assign new_entry = {in_key_q, in_handle_q};

  // directory probe at the scan index
  assign bsc_idx   = bsc_q[BW-1:0];
  assign cur_fill  = fill_q[bsc_idx];
  assign cur_shard = bshard_q[bsc_idx];
  assign e_hit     = (cur_fill == '0) && !have_empty_q;
  assign f_hit     = (cur_fill != '0) && (cur_shard == in_shard_q);
  assign scan_end  = (bsc_q == (BW+1)'(BUCKETS - 1));
  assign dir_empty = have_empty_q || (cur_fill == '0);
  assign empty_sel = have_empty_q ? empty_q : bsc_idx;
  assign dir_found = f_hit;

  // entry compares
  assign key_match = (rd_key.sender == in_key_q.sender) && (rd_key.nonce == in_key_q.nonce);
  assign hash_gt   = in_key_q.hash > rd_key.hash;
  assign hash_lt   = in_key_q.hash < rd_key.hash;
  assign new_lt    = (in_key_q.sender < rd_key.sender) ||
                     ((in_key_q.sender == rd_key.sender) && (in_key_q.nonce < rd_key.nonce));
  assign i_next    = (CW+1)'(i_q) + (CW+1)'(1);

  assign cnt_ext_res = 32'(res_cnt_q);
  assign cnt_ext_n   = 32'(n_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    bsc_d        = bsc_q;
    have_empty_d = have_empty_q;
    empty_d      = empty_q;
    tgt_d        = tgt_q;
    newb_d       = newb_q;
    n_d          = n_q;
    i_d          = i_q;
    at_d         = at_q;
    res_status_d = res_status_q;
    res_cnt_d    = res_cnt_q;
    fill_d       = fill_q;
    bshard_d     = bshard_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = slot_addr(tgt_q, at_q);
    ram_raddr    = slot_addr(tgt_q, i_q);
    ram_wdata    = new_entry;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_shard_d  = out_shard_q;
    out_cnt_d    = out_cnt_q;
    out_hash_d   = out_hash_q;
    out_handle_d = out_handle_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          bsc_d        = '0;
          have_empty_d = 1'b0;
          newb_d       = 1'b0;
          i_d          = '0;
          if ({1'b0, shard_id_i} >= shard_lim_q) begin
            res_status_d = ST_BAD_SHARD;
            res_cnt_d    = '0;
            state_d      = S_FIN;
          end else begin
            state_d = S_DSCAN;
          end
        end
      end
      S_DSCAN: begin
        if (e_hit) begin
          have_empty_d = 1'b1;
          empty_d      = bsc_idx;
        end
        if (dir_found) begin
          tgt_d = bsc_idx;
          n_d   = cur_fill;
          state_d = in_action_q ? S_LRD : S_MRD;
        end else if (scan_end) begin
          if (in_action_q) begin
            res_status_d = ST_LIST_EMPTY;
            res_cnt_d    = '0;
            state_d      = S_FIN;
          end else if (dir_empty) begin
            tgt_d   = empty_sel;
            newb_d  = 1'b1;
            n_d     = '0;
            at_d    = '0;
            state_d = S_INS;
          end else begin
            res_status_d = ST_FULL;
            res_cnt_d    = '0;
            state_d      = S_FIN;
          end
        end else begin
          bsc_d = bsc_q + 1'b1;
        end
      end
      S_LRD: begin
        ram_re  = 1'b1;
        state_d = S_LWAIT;
      end
      S_LWAIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_LIST;
          out_shard_d  = in_shard_q;
          out_cnt_d    = cnt_ext_n[4:0];
          out_hash_d   = '0;
          out_handle_d = rh_ext[15:0];
          out_last_d   = (i_next == (CW+1)'(n_q));
          if (i_next == (CW+1)'(n_q)) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_next[CW-1:0];
            state_d = S_LRD;
          end
        end
      end
      S_MRD: begin
        if (i_q == n_q) begin
          if (32'(n_q) >= PER_SHARD) begin
            res_status_d = ST_FULL;
            res_cnt_d    = n_q;
            state_d      = S_FIN;
          end else begin
            at_d    = n_q;
            state_d = S_INS;
          end
        end else begin
          ram_re  = 1'b1;
          state_d = S_MCHK;
        end
      end
      S_MCHK: begin
        res_cnt_d = n_q;
        if (key_match) begin
          state_d = S_FIN;
          if (hash_gt) begin
            res_status_d = ST_NOT_PREF;
          end else if (hash_lt) begin
            // sender and nonce equal, so the whole entry can be rewritten
            ram_we       = 1'b1;
            ram_waddr    = slot_addr(tgt_q, i_q);
            res_status_d = ST_REPLACED;
          end else begin
            res_status_d = ST_DUPLICATE;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_MRD;
        end
      end
      S_INS: begin
        if (at_q == '0) begin
          ram_we       = 1'b1;
          fill_d[tgt_q] = n_q + 1'b1;
          if (newb_q) begin
            bshard_d[tgt_q] = in_shard_q;
          end
          res_status_d = ST_INSERTED;
          res_cnt_d    = n_q + 1'b1;
          state_d      = S_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(tgt_q, at_q - 1'b1);
          state_d   = S_ICHK;
        end
      end
      S_ICHK: begin
        ram_we = 1'b1;
        if (new_lt) begin
          // move the larger entry up one slot
          ram_wdata = ram_rdata;
          at_d      = at_q - 1'b1;
          state_d   = S_INS;
        end else begin
          fill_d[tgt_q] = n_q + 1'b1;
          if (newb_q) begin
            bshard_d[tgt_q] = in_shard_q;
          end
          res_status_d = ST_INSERTED;
          res_cnt_d    = n_q + 1'b1;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_shard_d  = in_shard_q;
          out_cnt_d    = cnt_ext_res[4:0];
          out_hash_d   = (res_status_q == ST_INSERTED || res_status_q == ST_REPLACED ||
                          res_status_q == ST_DUPLICATE) ? in_key_q.hash : '0;
          out_handle_d = '0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      shard_lim_q   <= CountBits'(1);
      out_valid_q   <= 1'b0;
      have_empty_q  <= 1'b0;
      bsc_q         <= '0;
      for (int b = 0; b < BUCKETS; b++) begin
        fill_q[b] <= '0;
      end
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      have_empty_q <= have_empty_d;
      bsc_q        <= bsc_d;
      fill_q       <= fill_d;
      if (cfg_we_i) begin
        shard_lim_q <= cfg_wdata_i;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    empty_q      <= empty_d;
    tgt_q        <= tgt_d;
    newb_q       <= newb_d;
    n_q          <= n_d;
    i_q          <= i_d;
    at_q         <= at_d;
    res_status_q <= res_status_d;
    res_cnt_q    <= res_cnt_d;
    bshard_q     <= bshard_d;
    out_status_q <= out_status_d;
    out_shard_q  <= out_shard_d;
    out_cnt_q    <= out_cnt_d;
    out_hash_q   <= out_hash_d;
    out_handle_q <= out_handle_d;
    out_last_q   <= out_last_d;
    if (in_acc) begin
      in_action_q     <= action_i;
      in_shard_q      <= shard_id_i;
      in_key_q.sender <= {sender_w0_i, sender_w1_i, sender_w2_i, sender_w3_i};
      in_key_q.nonce  <= nonce_i;
      in_key_q.hash   <= {hash_w0_i, hash_w1_i, hash_w2_i, hash_w3_i};
      in_handle_q     <= fh_ext[HANDLE_BITS-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign shard_out_o      = out_shard_q;
  assign bucket_len_o     = out_cnt_q;
  assign result_hash_w0_o = out_hash_q[255:192];
  assign result_hash_w1_o = out_hash_q[191:128];
  assign result_hash_w2_o = out_hash_q[127:64];
  assign result_hash_w3_o = out_hash_q[63:0];
  assign out_handle_o     = out_handle_q;
  assign last_o           = out_last_q;

  // entry RAM is only written while inserting or replacing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_MCHK || state_q == S_INS || state_q == S_ICHK))
    else $error("entry RAM written outside insert or replace");

  // the bucket at the scan index never holds more than its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_fill) <= PER_SHARD)
    else $error("bucket fill above capacity");

  // a finished result frees the sequencer on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (state_q == S_IDLE && out_valid_q && last_o))
    else $error("final result not issued");

endmodule
`default_nettype wire

// ===== tb/pool_checker.sv =====
module pool_checker
  import ssp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] shard_id_i,
  input  logic [63:0] sender_w0_i,
  input  logic [63:0] sender_w1_i,
  input  logic [63:0] sender_w2_i,
  input  logic [63:0] sender_w3_i,
  input  logic [63:0] nonce_i,
  input  logic [63:0] hash_w0_i,
  input  logic [63:0] hash_w1_i,
  input  logic [63:0] hash_w2_i,
  input  logic [63:0] hash_w3_i,
  input  logic [15:0] frame_handle_i,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [2:0]  status_o,
  input  logic [15:0] shard_out_o,
  input  logic [4:0]  bucket_len_o,
  input  logic [63:0] result_hash_w0_o,
  input  logic [63:0] result_hash_w1_o,
  input  logic [63:0] result_hash_w2_o,
  input  logic [63:0] result_hash_w3_o,
  input  logic [15:0] out_handle_o,
  input  logic        last_o,
  output int          fail_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBKT = 8;
  localparam int DEPTH = 16;

  typedef struct packed {
    ssp_status_e st;
    logic [15:0]  shard;
    logic [4:0]   cnt;
    logic [255:0] hash;
    logic [15:0]  handle;
    logic         last;
  } pool_result_t;

  typedef struct packed {
    logic [255:0] sender;
    logic [63:0]  nonce;
    logic [255:0] hash;
    logic [15:0]  handle;
  } pool_entry_t;

  pool_result_t result_q[$];
  logic [16:0]  shard_lim;
  int           fill[NBKT];
  logic [15:0]  owner[NBKT];
  pool_entry_t  slot[NBKT][DEPTH];

  assign pending_results = result_q.size();

  task automatic report_mismatch(input string what, input logic [255:0] got,
                                 input logic [255:0] want);
    $display("%0t: %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic pool_result_t mk(ssp_status_e st, logic [15:0] sh, int cnt,
                                      logic [255:0] h, logic [15:0] hd, logic l);
    pool_result_t r;
    r.st = st; r.shard = sh; r.cnt = cnt[4:0]; r.hash = h; r.handle = hd; r.last = l;
    return r;
  endfunction

  // work out the results of one accepted item and update the pool copy
  task automatic predict_pool(input logic act, input logic [15:0] sh, input pool_entry_t e);
    int found, free_b, n, at, b;
    found = -1; free_b = -1;
    if ({1'b0, sh} >= shard_lim) begin
      result_q.push_back(mk(ST_BAD_SHARD, sh, 0, '0, '0, 1'b1));
      return;
    end
    for (int i = 0; i < NBKT; i++) begin
      if (fill[i] == 0) begin
        if (free_b < 0) free_b = i;
      end else if (owner[i] == sh) begin
        found = i;
        break;
      end
    end
    if (act) begin
      if (found < 0) begin
        result_q.push_back(mk(ST_LIST_EMPTY, sh, 0, '0, '0, 1'b1));
      end else begin
        n = fill[found];
        for (int i = 0; i < n; i++)
          result_q.push_back(mk(ST_LIST, sh, n, '0, slot[found][i].handle, i == n - 1));
      end
      return;
    end
    if (found >= 0) begin
      n = fill[found];
      for (int i = 0; i < n; i++) begin
        if (slot[found][i].nonce == e.nonce && slot[found][i].sender == e.sender) begin
          if (e.hash > slot[found][i].hash)
            result_q.push_back(mk(ST_NOT_PREF, sh, n, '0, '0, 1'b1));
          else if (e.hash < slot[found][i].hash) begin
            slot[found][i].hash = e.hash;
            slot[found][i].handle = e.handle;
            result_q.push_back(mk(ST_REPLACED, sh, n, e.hash, '0, 1'b1));
          end else
            result_q.push_back(mk(ST_DUPLICATE, sh, n, e.hash, '0, 1'b1));
          return;
        end
      end
      if (n >= DEPTH) begin
        result_q.push_back(mk(ST_FULL, sh, n, '0, '0, 1'b1));
        return;
      end
      b = found;
    end else begin
      if (free_b < 0) begin
        result_q.push_back(mk(ST_FULL, sh, 0, '0, '0, 1'b1));
        return;
      end
      b = free_b;
      owner[b] = sh;
    end
    // insertion sort by sender then nonce
    at = fill[b];
    while (at > 0 && (e.sender < slot[b][at-1].sender ||
           (e.sender == slot[b][at-1].sender && e.nonce < slot[b][at-1].nonce))) begin
      slot[b][at] = slot[b][at-1];
      at--;
    end
    slot[b][at] = e;
    fill[b]++;
    result_q.push_back(mk(ST_INSERTED, sh, fill[b], e.hash, '0, 1'b1));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pool_entry_t e;
    pool_result_t w;
    if (!rst_ni) begin
      shard_lim <= 17'd1;
      for (int i = 0; i < NBKT; i++) fill[i] = 0;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we_i) shard_lim <= cfg_wdata_i;
      // compare the result item first; it was queued by an earlier item
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result item with nothing expected", $time);
          fail_count++;
        end else begin
          w = result_q.pop_front();
          if (status_o !== w.st) report_mismatch("status", status_o, w.st);
          if (shard_out_o !== w.shard) report_mismatch("shard_out", shard_out_o, w.shard);
          if (bucket_len_o !== w.cnt) report_mismatch("bucket_len", bucket_len_o, w.cnt);
          if (result_hash_w0_o !== w.hash[255:192])
            report_mismatch("result_hash_w0", result_hash_w0_o, w.hash[255:192]);
          if (result_hash_w1_o !== w.hash[191:128])
            report_mismatch("result_hash_w1", result_hash_w1_o, w.hash[191:128]);
          if (result_hash_w2_o !== w.hash[127:64])
            report_mismatch("result_hash_w2", result_hash_w2_o, w.hash[127:64]);
          if (result_hash_w3_o !== w.hash[63:0])
            report_mismatch("result_hash_w3", result_hash_w3_o, w.hash[63:0]);
          if (out_handle_o !== w.handle) report_mismatch("out_handle", out_handle_o, w.handle);
          if (last_o !== w.last) report_mismatch("last", last_o, w.last);
        end
      end
      if (in_valid_i && in_ready_o) begin
        e.sender = {sender_w0_i, sender_w1_i, sender_w2_i, sender_w3_i};
        e.nonce  = nonce_i;
        e.hash   = {hash_w0_i, hash_w1_i, hash_w2_i, hash_w3_i};
        e.handle = frame_handle_i;
        predict_pool(action_i, shard_id_i, e);
      end
    end
  end
endmodule

// ===== tb/tb.sv =====
module tb;
  import ssp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        action_i = 1'b0;
  logic [15:0] shard_id_i = '0;
  logic [63:0] sender_w0_i = '0, sender_w1_i = '0, sender_w2_i = '0, sender_w3_i = '0;
  logic [63:0] nonce_i = '0;
  logic [63:0] hash_w0_i = '0, hash_w1_i = '0, hash_w2_i = '0, hash_w3_i = '0;
  logic [15:0] frame_handle_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] shard_out_o;
  logic [4:0]  bucket_len_o;
  logic [63:0] result_hash_w0_o, result_hash_w1_o, result_hash_w2_o, result_hash_w3_o;
  logic [15:0] out_handle_o;
  logic        last_o;
  int          fail_count;
  int          pending_results;
  int          send_idle_pct = 35;
  int          recv_idle_pct = 53;
  int          cycle_no = 0;

  // small pools of keys so that matches, replacements and full buckets occur
  logic [255:0] key_pool[4];
  logic [15:0]  shard_pick;

  sharded_sorted_pending_pool dut (.*);
  pool_checker u_checker (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  // valid drops only while the sender idles, so items can follow back to back
  task automatic send_item(input logic act, input logic [15:0] sh, input logic [255:0] snd,
                           input logic [63:0] nc, input logic [255:0] h,
                           input logic [15:0] hd);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    shard_id_i <= sh;
    {sender_w0_i, sender_w1_i, sender_w2_i, sender_w3_i} <= snd;
    nonce_i <= nc;
    {hash_w0_i, hash_w1_i, hash_w2_i, hash_w3_i} <= h;
    frame_handle_i <= hd;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  function automatic logic [255:0] rnd256();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic write_shards(input logic [16:0] v);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item(input int lim);
    logic [255:0] snd;
    logic [255:0] h;
    snd = ($urandom_range(3) != 0) ? key_pool[$urandom_range(3)] : rnd256();
    h = ($urandom_range(3) == 0) ? rnd256() : {252'd0, 4'($urandom)};
    shard_pick = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(lim));
    send_item($urandom_range(5) == 0, shard_pick, snd, 64'($urandom_range(5)) |
              (($urandom_range(7) == 0) ? {$urandom, $urandom} : 64'd0), h, 16'($urandom));
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = rnd256();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset limit of one shard
    send_item(1'b1, 16'd0, '0, '0, '0, '0);
    send_item(1'b0, 16'd1, '0, '0, '0, 16'h1);
    send_item(1'b0, 16'd0, '1, '1, '1, 16'hffff);
    send_item(1'b0, 16'd0, '0, '0, '1, 16'h0002);
    send_item(1'b0, 16'd0, '0, '0, '0, 16'h0003);
    send_item(1'b0, 16'd0, '0, '0, '0, 16'h0004);
    send_item(1'b0, 16'd0, '0, '0, {255'd0, 1'b1}, 16'h0005);
    send_item(1'b0, 16'd0, key_pool[0], 64'd7, '0, 16'h0006);
    send_item(1'b0, 16'd0, key_pool[0], 64'd3, '0, 16'h0007);
    send_item(1'b1, 16'd0, '0, '0, '0, '0);
    write_shards(17'd0);
    send_item(1'b0, 16'd0, '0, '0, '0, '0);
    write_shards(17'd65536);
    send_item(1'b0, 16'hffff, '1, '0, '1, 16'hffff);
    send_item(1'b1, 16'hffff, '0, '0, '0, '0);
    send_item(1'b1, 16'h1234, '0, '0, '0, '0);
    // fill every bucket, then ask for more
    for (int s = 1; s <= 7; s++) send_item(1'b0, 16'(s), rnd256(), '0, '0, 16'(s));
    send_item(1'b0, 16'd100, '0, '0, '0, '0);

    // random phases with several limits and idle settings
    for (int ph = 0; ph < 6; ph++) begin
      write_shards((ph % 3 == 0) ? 17'd65536 : ((ph % 3 == 1) ? 17'd12 : 17'd1));
      if (ph == 2) begin send_idle_pct = 53; recv_idle_pct = 35; end
      if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
      // each phase draws a fresh key pool
      foreach (key_pool[i]) key_pool[i] = rnd256();
      for (int i = 0; i < 58; i++)
        random_item((ph % 3 == 0) ? 8 : ((ph % 3 == 1) ? 11 : 0));
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    if (fail_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/ssp_pkg.sv
rtl/core/ssp_ram.sv
rtl/core/sharded_sorted_pending_pool.sv
tb/pool_checker.sv
tb/tb.sv
